// ----- design/stereo_correlation_cost_volume_assert.svh -----
`ifndef STEREO_CORRELATION_COST_VOLUME_ASSERT_SVH
`define STEREO_CORRELATION_COST_VOLUME_ASSERT_SVH
// same-cycle implication, sampled on clk, off during rst
`define SCV_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scv check failed");
// next-cycle implication, sampled on clk, off during rst
`define SCV_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scv check failed");
`endif

// ----- design/scv_pkg.sv -----
package scv_pkg;

  localparam int DISP_SLOTS   = 16;
  localparam int HIST_COLS    = DISP_SLOTS - 1;
  localparam int MAX_CHANNELS = 256;
  localparam int HIST_DEPTH   = HIST_COLS * MAX_CHANNELS;
  localparam int HIST_AW      = 12;
  localparam int SUM_W        = 40;
  localparam int DISP_W       = 4;

  localparam logic [1:0] REG_DISPARITY_COUNT    = 2'd0;
  localparam logic [1:0] REG_CHANNELS_PER_GROUP = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_DRAIN,
    ST_RD,
    ST_START,
    ST_DIV,
    ST_OUT
  } state_t;

  // column modulo the ring length (16 is 1 mod 15, so sum the nibbles)
  function automatic logic [3:0] col_mod15(input logic [9:0] col);
    logic [5:0] s;
    begin
      s = 6'(col[9:8]) + 6'(col[7:4]) + 6'(col[3:0]);
      if (s >= 6'd30) begin
        s = s - 6'd30;
      end else if (s >= 6'd15) begin
        s = s - 6'd15;
      end
      col_mod15 = s[3:0];
    end
  endfunction

endpackage

// ----- design/scv_div.sv -----
module scv_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic signed [scv_pkg::SUM_W-1:0] dividend,
  input  logic        [8:0]                divisor,
  output logic                             done,
  output logic signed [scv_pkg::SUM_W-1:0] quotient
);
  import scv_pkg::*;

  logic             busy;
  logic [5:0]       cnt;
  logic [8:0]       rem;
  logic [SUM_W-1:0] mag;
  logic             neg;
  logic [9:0]       trial;

  assign trial    = {rem, mag[SUM_W-1]};
  assign quotient = neg ? -$signed(mag) : $signed(mag);

  // control: one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == 6'(SUM_W - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'(SUM_W - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // restoring divide on the magnitude
  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[SUM_W-1];
      mag <= dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
      rem <= '0;
    end else if (busy) begin
      if (trial >= {1'b0, divisor}) begin
        rem <= 9'(trial - {1'b0, divisor});
        mag <= {mag[SUM_W-2:0], 1'b1};
      end else begin
        rem <= trial[8:0];
        mag <= {mag[SUM_W-2:0], 1'b0};
      end
    end
  end

endmodule

// ----- design/stereo_correlation_cost_volume.sv -----
// an item that is not its pixel's last channel is accumulated (ACC) and drained (DRAIN)
// last channel: then, per disparity, a sum read, a 40-step divide and the output
// one item at a time; each item makes 16 history/sum memory reads
// reset: config returns to 16 disparities and 1 channel; history is undefined
// until written, so no clearing pass runs; sums read as zero after reset and at channel zero
module stereo_correlation_cost_volume (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [8:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [9:0]         column,
  input  logic [7:0]         channel,
  input  logic signed [15:0] left_value,
  input  logic signed [15:0] right_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [3:0]         disparity,
  output logic signed [31:0] cost_value,
  output logic               last_of_pixel
);
  import scv_pkg::*;

  localparam logic signed [SUM_W-1:0] COST_MAX = SUM_W'(64'sd1073741824);
  localparam logic signed [SUM_W-1:0] COST_MIN = SUM_W'(-64'sd1073741824);

  state_t state, state_next;

  logic [4:0]  disparity_count;
  logic [8:0]  channels_per_group;
  logic [4:0]  dc_eff;
  logic [8:0]  cpg_eff;

  logic [9:0]         col_q;
  logic [7:0]         ch_q;
  logic signed [15:0] lv_q;
  logic signed [15:0] rv_q;
  logic [3:0]         cm;
  logic [3:0]         slot;
  logic [DISP_W-1:0]  d_cnt;

  logic signed [15:0]      hist_mem [0:HIST_DEPTH-1];
  logic signed [15:0]      hist_q;
  logic signed [SUM_W-1:0] sum_mem [0:DISP_SLOTS-1];
  logic signed [SUM_W-1:0] sum_q;
  logic [DISP_SLOTS-1:0]   sum_seen;

  logic                    s1_valid, s2_valid;
  logic [DISP_W-1:0]       s1_d, s2_d;
  logic signed [15:0]      s1_r;
  logic signed [31:0]      prod;
  logic signed [SUM_W-1:0] sum_base;

  logic                    div_start, div_done;
  logic signed [SUM_W-1:0] quo;
  logic signed [31:0]      cost;
  logic                    in_take, out_free, is_last_ch, is_last_d;

  assign in_take    = in_valid && !in_stall;
  assign in_stall   = (state != ST_IDLE);
  assign out_free   = !out_valid || !out_stall;
  assign dc_eff     = (disparity_count == 5'd0) ? 5'd1 :
                      (disparity_count > 5'(DISP_SLOTS)) ? 5'(DISP_SLOTS) : disparity_count;
  assign cpg_eff    = (channels_per_group == 9'd0) ? 9'd1 :
                      (channels_per_group > 9'(MAX_CHANNELS)) ? 9'(MAX_CHANNELS)
                                                              : channels_per_group;
  assign is_last_ch = ({1'b0, ch_q} == 9'(cpg_eff - 9'd1));
  assign is_last_d  = ({1'b0, d_cnt} == 5'(dc_eff - 5'd1));
  assign div_start  = (state == ST_START);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      disparity_count    <= 5'd16;
      channels_per_group <= 9'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DISPARITY_COUNT:    disparity_count    <= cfg_data[4:0];
        REG_CHANNELS_PER_GROUP: channels_per_group <= cfg_data;
        default: ;
      endcase
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_take) state_next = ST_ACC;
      ST_ACC:   if (d_cnt == DISP_W'(DISP_SLOTS - 1)) state_next = ST_DRAIN;
      ST_DRAIN: begin
        if (s2_valid && s2_d == DISP_W'(DISP_SLOTS - 1)) begin
          state_next = is_last_ch ? ST_RD : ST_IDLE;
        end
      end
      ST_RD:    state_next = ST_START;
      ST_START: state_next = ST_DIV;
      ST_DIV:   if (div_done) state_next = ST_OUT;
      ST_OUT: begin
        if (out_free) state_next = is_last_d ? ST_IDLE : ST_RD;
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  // request capture and disparity counter
  always_ff @(posedge clk) begin
    if (in_take) begin
      col_q <= column;
      ch_q  <= channel;
      lv_q  <= left_value;
      rv_q  <= right_value;
      cm    <= col_mod15(column);
      slot  <= col_mod15(column);
      d_cnt <= '0;
    end else if (state == ST_ACC) begin
      d_cnt <= d_cnt + DISP_W'(1);
      slot  <= (slot == 4'd0) ? 4'(HIST_COLS - 1) : slot - 4'd1;
    end else if (state == ST_DRAIN) begin
      d_cnt <= '0;
    end else if (state == ST_OUT && out_free) begin
      d_cnt <= d_cnt + DISP_W'(1);
    end
  end

  // history ring: read per disparity, current column written after the last read
  always_ff @(posedge clk) begin
    hist_q <= hist_mem[HIST_AW'({slot, ch_q})];
    if (s1_valid && s1_d == DISP_W'(DISP_SLOTS - 1)) begin
      hist_mem[HIST_AW'({cm, ch_q})] <= rv_q;
    end
  end

  // accumulator memory: read, multiply-add, write back
  always_ff @(posedge clk) begin
    sum_q <= sum_mem[d_cnt];
    if (s2_valid) begin
      sum_mem[s2_d] <= sum_base + SUM_W'(prod);
    end
  end

  // accumulators not yet written since reset read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_seen <= '0;
    end else if (s2_valid) begin
      sum_seen[s2_d] <= 1'b1;
    end
  end

  // pipeline valid tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= (state == ST_ACC);
      s2_valid <= s1_valid;
    end
  end

  // right operand per disparity, zero left of the image edge
  always_comb begin
    if (s1_d == '0) begin
      s1_r = rv_q;
    end else if (col_q >= 10'(s1_d)) begin
      s1_r = hist_q;
    end else begin
      s1_r = '0;
    end
  end

  // product and base stage
  always_ff @(posedge clk) begin
    s1_d     <= d_cnt;
    s2_d     <= s1_d;
    prod     <= lv_q * s1_r;
    sum_base <= (ch_q == 8'd0 || !sum_seen[s1_d]) ? '0 : sum_q;
  end

  scv_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum_q),
    .divisor  (cpg_eff),
    .done     (div_done),
    .quotient (quo)
  );

  // clamp and edge zeroing
  always_comb begin
    if (col_q < 10'(d_cnt)) begin
      cost = '0;
    end else if (quo > COST_MAX) begin
      cost = 32'(COST_MAX);
    end else if (quo < COST_MIN) begin
      cost = 32'(COST_MIN);
    end else begin
      cost = quo[31:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) begin
      disparity     <= d_cnt;
      cost_value    <= cost;
      last_of_pixel <= is_last_d;
    end
  end

endmodule

// ----- design/scv_checker.sv -----
module scv_port_props (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [3:0]         disparity,
  input logic signed [31:0] cost_value,
  input logic               last_of_pixel
);
`include "stereo_correlation_cost_volume_assert.svh"

  // a stalled result keeps its payload
  `SCV_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(cost_value) && $stable(disparity) && $stable(last_of_pixel))
  // costs stay within the Q16.16 clamp
  `SCV_ASSERT_NOW(a_cost_range, out_valid, cost_value <= 32'sd1073741824 && cost_value >= -32'sd1073741824)
  // one request at a time: busy right after accepting
  `SCV_ASSERT_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall)
  // a non-final disparity is followed by the next one, never a jump back to zero
  `SCV_ASSERT_NEXT(a_disp_order, out_valid && !out_stall && !last_of_pixel, !out_valid || disparity != 4'd0)

endmodule

bind stereo_correlation_cost_volume scv_port_props u_scv_port_props (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .disparity     (disparity),
  .cost_value    (cost_value),
  .last_of_pixel (last_of_pixel)
);

// ----- bench/scv_checker.sv -----
`timescale 1ns / 1ps

module scv_checker
  import scv_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [8:0]         cfg_data,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [9:0]         column,
  input  logic [7:0]         channel,
  input  logic signed [15:0] left_value,
  input  logic signed [15:0] right_value,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [3:0]         disparity,
  input  logic signed [31:0] cost_value,
  input  logic               last_of_pixel,
  output int                 fail_count,
  output int                 pending
);

  typedef struct packed {
    logic [3:0]         disp;
    logic signed [31:0] cost;
    logic               last;
  } cost_rec_t;

  // local copy of block state
  logic signed [15:0] right_ring [HIST_COLS][MAX_CHANNELS];
  logic signed [39:0] corr_sums [DISP_SLOTS];
  logic [4:0]         disp_count;
  logic [8:0]         chan_count;
  cost_rec_t          cost_q [$];

  // accumulate one channel and queue the costs of a finished pixel
  task automatic predict_costs(input logic [9:0] col, input logic [7:0] ch,
                               input logic signed [15:0] lv,
                               input logic signed [15:0] rv);
    int         dc;
    int         cpg;
    longint     prod;
    longint     cost;
    logic signed [15:0] rsel;
    cost_rec_t  rec;
    dc  = (disp_count == 0) ? 1 : (disp_count > DISP_SLOTS ? DISP_SLOTS : disp_count);
    cpg = (chan_count == 0) ? 1 :
          (chan_count > MAX_CHANNELS ? MAX_CHANNELS : chan_count);
    if (ch == 0) begin
      for (int d = 0; d < DISP_SLOTS; d++) corr_sums[d] = '0;
    end
    // all reads happen before this column's slot is overwritten
    for (int d = 0; d < DISP_SLOTS; d++) begin
      rsel = '0;
      if (d == 0) begin
        rsel = rv;
      end else if (col >= d) begin
        rsel = right_ring[(col - d) % HIST_COLS][ch];
      end
      prod = longint'(lv) * longint'(rsel);
      corr_sums[d] = corr_sums[d] + prod[39:0];
    end
    right_ring[col % HIST_COLS][ch] = rv;
    if (ch == cpg - 1) begin
      for (int d = 0; d < dc; d++) begin
        cost = 0;
        if (col >= d) cost = longint'(corr_sums[d]) / longint'(cpg);
        if (cost > 64'sd1073741824) cost = 64'sd1073741824;
        if (cost < -64'sd1073741824) cost = -64'sd1073741824;
        rec.disp = d[3:0];
        rec.cost = cost[31:0];
        rec.last = (d == dc - 1);
        cost_q.push_back(rec);
      end
    end
  endtask

  always @(posedge clk) begin
    cost_rec_t exp_rec;
    int        errs;
    errs = 0;
    if (rst) begin
      disp_count <= 5'd16;
      chan_count <= 9'd1;
      for (int d = 0; d < DISP_SLOTS; d++) corr_sums[d] = '0;
      cost_q.delete();
      fail_count <= 0;
      pending    <= 0;
    end else begin
      // compare a taken result with the oldest expected cost
      if (out_valid && !out_stall) begin
        if (cost_q.size() == 0) begin
          $error("unexpected result: disparity %0d cost %0d", disparity, cost_value);
          errs++;
        end else begin
          exp_rec = cost_q.pop_front();
          if (disparity !== exp_rec.disp) begin
            $error("disparity: expected %0d, got %0d", exp_rec.disp, disparity);
            errs++;
          end
          if (cost_value !== exp_rec.cost) begin
            $error("cost_value: expected %0d, got %0d", exp_rec.cost, cost_value);
            errs++;
          end
          if (last_of_pixel !== exp_rec.last) begin
            $error("last_of_pixel: expected %0d, got %0d", exp_rec.last, last_of_pixel);
            errs++;
          end
        end
      end
      // register writes
      if (cfg_we) begin
        if (cfg_index == REG_DISPARITY_COUNT) disp_count <= cfg_data[4:0];
        else if (cfg_index == REG_CHANNELS_PER_GROUP) chan_count <= cfg_data;
      end
      // accepted request
      if (in_valid && !in_stall) begin
        predict_costs(column, channel, left_value, right_value);
      end
      fail_count <= fail_count + errs;
      pending    <= cost_q.size();
    end
  end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import scv_pkg::*;

  localparam logic [1:0] REG_SPARE_A = 2'd2;
  localparam logic [1:0] REG_SPARE_B = 2'd3;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int SETTLE_CYCLES = 150;
  localparam int ITEM_TARGET = 360;

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [1:0]         cfg_index;
  logic [8:0]         cfg_data;
  logic               in_valid;
  logic               in_stall;
  logic [9:0]         column;
  logic [7:0]         channel;
  logic signed [15:0] left_value;
  logic signed [15:0] right_value;
  logic               out_valid;
  logic               out_stall;
  logic [3:0]         disparity;
  logic signed [31:0] cost_value;
  logic               last_of_pixel;
  int                 fail_count;
  int                 pending;
  int                 cycles;
  int                 items_sent;
  int                 burst_left;
  int                 cur_cpg;
  bit                 ring_written [HIST_COLS][MAX_CHANNELS];

  stereo_correlation_cost_volume u_top (.*);

  scv_checker u_chk (.*);

  // clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // receiver stall pattern: switches at random between four modes
  int stall_mode;
  always @(posedge clk) begin
    if (cycles % 64 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 1) == 1);
      2: out_stall <= ($urandom_range(0, 7) != 0);
      default: out_stall <= ((cycles / 5) % 2 == 1);
    endcase
  end

  // true when every history entry the request reads was written before
  function automatic bit ring_ready(input int col, input int ch);
    ring_ready = 1'b1;
    for (int d = 1; d < DISP_SLOTS; d++) begin
      if (col >= d && !ring_written[(col - d) % HIST_COLS][ch]) ring_ready = 1'b0;
    end
  endfunction

  task automatic write_reg(input logic [1:0] idx, input int val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[8:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // let everything drain before touching registers
  task automatic settle();
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // one request, sent in bursts with random gaps between them
  task automatic send_request(input int col, input int ch,
                              input logic signed [15:0] lv,
                              input logic signed [15:0] rv);
    if (burst_left == 0) begin
      if (in_valid) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_valid    <= 1'b1;
    column      <= col[9:0];
    channel     <= ch[7:0];
    left_value  <= lv;
    right_value <= rv;
    do @(posedge clk); while (in_stall);
    ring_written[col % HIST_COLS][ch] = 1'b1;
    items_sent++;
  endtask

  task automatic idle_bus();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
  endtask

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(0, 7))
      0: rand_sample = 16'sh7FFF;
      1: rand_sample = 16'sh8000;
      default: rand_sample = 16'($urandom);
    endcase
  endfunction

  // whole pixel; falls back to column zero when history is missing
  task automatic send_pixel(input int col);
    for (int ch = 0; ch < cur_cpg; ch++) begin
      if (!ring_ready(col, ch)) col = 0;
    end
    for (int ch = 0; ch < cur_cpg; ch++) begin
      send_request(col, ch, rand_sample(), rand_sample());
    end
  endtask

  task automatic set_config(input int dc, input int cpg);
    settle();
    write_reg(REG_DISPARITY_COUNT, dc);
    write_reg(REG_CHANNELS_PER_GROUP, cpg);
    cur_cpg = (cpg == 0) ? 1 : (cpg > MAX_CHANNELS ? MAX_CHANNELS : cpg);
  endtask

  initial begin
    int col;
    int ch;
    cycles = 0;
    items_sent = 0;
    burst_left = 0;
    cur_cpg = 1;
    stall_mode = 0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    out_stall = 1'b0;
    column = '0;
    channel = '0;
    left_value = '0;
    right_value = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: extremes of samples along one row, column below disparity
    for (int c = 0; c < 18; c++) begin
      send_request(c, 0, (c % 2) ? 16'sh8000 : 16'sh7FFF,
                   (c % 3) ? 16'sh8000 : 16'sh7FFF);
    end
    idle_bus();

    // out of range counts saturate or clamp, unused indexes ignored
    set_config(0, 0);
    write_reg(REG_SPARE_A, 9'h1FF);
    write_reg(REG_SPARE_B, 9'h0AA);
    send_pixel(18);
    send_pixel(19);
    idle_bus();
    set_config(31, 3);
    // channels out of order, and a channel past the last one
    send_request(0, 2, 16'sh7FFF, 16'sh8000);
    send_request(0, 1, 16'sh8000, 16'sh8000);
    send_request(0, 0, 16'sh0100, 16'sh0100);
    send_request(0, 3, 16'sh0100, 16'sh0200);
    send_request(0, 2, 16'sh0300, 16'sh0100);
    idle_bus();
    set_config(1, 511);
    send_pixel(0);
    idle_bus();

    // random phases, mostly well-formed rows with some noise
    while (items_sent < ITEM_TARGET) begin
      set_config($urandom_range(0, 31),
                 ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6));
      if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE_A, $urandom);
      col = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 1023 - 20);
      repeat ($urandom_range(3, 20)) begin
        if ($urandom_range(0, 9) == 0) begin
          // noise request at any position the history allows
          ch = $urandom_range(0, 255);
          col = $urandom_range(0, 1023);
          if (!ring_ready(col, ch)) col = 0;
          send_request(col, ch, rand_sample(), rand_sample());
        end else begin
          send_pixel(col);
          col = (col + 1) % 1024;
        end
      end
      idle_bus();
    end

    settle();
    if (fail_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
